### rtl/core/swmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_pkg: shared types for the sliding window min/max block
// Sample width, request and result payloads, and the scan token that
// travels along the cell chain.
// ----------------------------------------------------------------------------
package swmm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 7;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    end_of_sequence;
    } t_in;

    typedef struct packed {
        t_sample window_min;
        t_sample window_max;
    } t_out;

    typedef struct packed {
        logic    valid;
        t_sample lo;
        t_sample hi;
    } t_token;

endpackage : swmm_pkg
`default_nettype wire

### rtl/core/swmm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmm_cell: one stage of the window chain
// Holds one stored sample, shifted in from the left neighbor on each accepted
// request, and one scan token stage that folds the stored sample into the
// running min/max when this cell lies inside the current window.
// ----------------------------------------------------------------------------
module swmm_cell #(
    parameter int IDX   = 0,
    parameter int WIN_W = 7
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_shift,
    input  swmm_pkg::t_sample    i_sample,
    output swmm_pkg::t_sample    o_sample,
    input  wire [WIN_W-1:0]      i_win,
    input  swmm_pkg::t_token     i_tok,
    output swmm_pkg::t_token     o_tok
);

    swmm_pkg::t_sample r_sample;
    swmm_pkg::t_token  r_tok;
    swmm_pkg::t_token  n_tok;
    logic              in_window;

    assign in_window = i_win > WIN_W'(IDX);

    always_comb begin
        n_tok = i_tok;
        if (in_window) begin
            if (r_sample < i_tok.lo) begin
                n_tok.lo = r_sample;
            end
            if (r_sample > i_tok.hi) begin
                n_tok.hi = r_sample;
            end
        end
    end

    // store has no reset, entries beyond the fill count are never folded in
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.lo <= n_tok.lo;
        r_tok.hi <= n_tok.hi;
    end

    assign o_sample = r_sample;
    assign o_tok    = r_tok;

endmodule : swmm_cell
`default_nettype wire

### rtl/core/sliding_window_min_max.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_min_max: min and max over the last window_size samples
// Input channel (i_valid / o_stall) takes one signed sample and an
// end-of-sequence flag per request. Output channel (o_valid / i_stall)
// gives window_min and window_max once the window of the current sequence
// is full. The config channel (i_cfg_valid / o_cfg_ready) writes the
// window size; it is ready whenever reset is released and meant to be
// written while idle.
// Samples sit in a chain of MAX_WINDOW cells that shifts on each request.
// A request that yields a result sends a scan token down the chain, one
// cell per cycle, and the result is registered at the output once the
// token leaves the last cell; no new request is taken meanwhile. A request
// that yields no result leaves the input free for the next one.
// The next request is taken as soon as the result is in the output
// register, even while the receiver stalls it. A stalled result holds.
// Reset clears the fill count, the token chain and the output register and
// sets the window size to 3; stored samples are not cleared. Input and
// config are held off while reset is low.
// ----------------------------------------------------------------------------
module sliding_window_min_max #(
    parameter int MAX_WINDOW = 64
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  swmm_pkg::t_in                      i_data,
    output logic                               o_valid,
    input  wire                                i_stall,
    output swmm_pkg::t_out                     o_data,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [swmm_pkg::CFG_BITS-1:0]       i_cfg_data
);

    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (WIN_W > swmm_pkg::CFG_BITS) ? WIN_W : swmm_pkg::CFG_BITS;

    logic [swmm_pkg::CFG_BITS-1:0] r_win;
    logic [WIN_W-1:0]              r_fill;
    logic [WIN_W-1:0]              n_fill;
    logic [WIN_W-1:0]              fill_inc;
    logic [WIN_W-1:0]              win_eff;
    logic [CMP_W-1:0]              win_wide;
    logic                          r_busy;
    logic                          n_busy;
    logic                          r_start;
    logic                          n_start;
    swmm_pkg::t_sample             r_newest;
    logic                          r_pend_v;
    logic                          n_pend_v;
    swmm_pkg::t_out                r_pend;
    swmm_pkg::t_out                n_pend;
    logic                          r_out_v;
    logic                          n_out_v;
    swmm_pkg::t_out                r_out;
    swmm_pkg::t_out                n_out;
    swmm_pkg::t_out                scan_res;
    logic                          accept;
    logic                          has_res;
    logic                          out_free;

    swmm_pkg::t_sample smp [MAX_WINDOW];
    swmm_pkg::t_token  tok [MAX_WINDOW+1];

    assign o_stall     = r_busy || !i_rst_n;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = i_rst_n;
    assign o_valid     = r_out_v;
    assign o_data      = r_out;
    assign out_free    = !r_out_v || !i_stall;

    // window size: zero reads as one, oversize saturates
    assign win_wide = CMP_W'(r_win);
    always_comb begin
        if (win_wide == '0) begin
            win_eff = WIN_W'(1);
        end else if (win_wide > CMP_W'(MAX_WINDOW)) begin
            win_eff = WIN_W'(MAX_WINDOW);
        end else begin
            win_eff = WIN_W'(win_wide);
        end
    end

    assign fill_inc = (r_fill < WIN_W'(MAX_WINDOW)) ? r_fill + WIN_W'(1) : r_fill;
    assign has_res  = fill_inc >= win_eff;

    assign tok[0].valid = r_start;
    assign tok[0].lo    = r_newest;
    assign tok[0].hi    = r_newest;

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        swmm_cell #(
            .IDX   (k),
            .WIN_W (WIN_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (accept),
            .i_sample ((k == 0) ? i_data.sample : smp[(k == 0) ? 0 : k-1]),
            .o_sample (smp[k]),
            .i_win    (win_eff),
            .i_tok    (tok[k]),
            .o_tok    (tok[k+1])
        );
    end

    assign scan_res.window_min = tok[MAX_WINDOW].lo;
    assign scan_res.window_max = tok[MAX_WINDOW].hi;

    always_comb begin
        n_out_v  = r_out_v && i_stall;
        n_out    = r_out;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_busy   = r_busy;
        n_start  = 1'b0;
        n_fill   = r_fill;
        if (r_pend_v && out_free) begin
            n_out_v  = 1'b1;
            n_out    = r_pend;
            n_pend_v = 1'b0;
            n_busy   = 1'b0;
        end else if (tok[MAX_WINDOW].valid) begin
            if (out_free) begin
                n_out_v = 1'b1;
                n_out   = scan_res;
                n_busy  = 1'b0;
            end else begin
                // previous result still held downstream
                n_pend_v = 1'b1;
                n_pend   = scan_res;
            end
        end
        if (accept) begin
            n_start = has_res;
            n_busy  = has_res;
            n_fill  = i_data.end_of_sequence ? '0 : fill_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= swmm_pkg::CFG_BITS'(3);
            r_fill   <= '0;
            r_busy   <= 1'b0;
            r_start  <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_win <= i_cfg_data;
            end
            r_fill   <= n_fill;
            r_busy   <= n_busy;
            r_start  <= n_start;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
        r_pend <= n_pend;
        r_out  <= n_out;
        if (accept) begin
            r_newest <= i_data.sample;
        end
    end

endmodule : sliding_window_min_max
`default_nettype wire
